@@ design/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and codes for the move-to-front coder: action and status
// codes, the controller state, the search wave and the cell control bundle.
// ----------------------------------------------------------------------------
package mtf_pkg;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 9;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CODE   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // search wave that walks down the cell chain one cell per cycle
  typedef struct packed {
    logic             live;
    logic             decode;
    logic             found;
    logic [SYM_W-1:0] key;
    logic [SYM_W-1:0] pos;
    logic [SYM_W-1:0] data;
  } wave_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             load_en;
    logic [SYM_W-1:0] load_sym;
    logic             shift_en;
    logic [SYM_W-1:0] shift_pos;
    logic [LEN_W-1:0] list_len;
  } cell_ctl_t;

endpackage

@@ design/move_to_front_coder.sv @@
// ----------------------------------------------------------------------------
// move_to_front_coder
// Move-to-front coder over a chain of symbol cells with a search wave.
// Code item: a registered wave walks every cell, the result is captured at the
//   tail and then loaded into the output register. Clear and append items go
//   straight to that load. A new item is taken only after the result is loaded.
// Reset clears the list length, direction and control; cell contents stay.
// ----------------------------------------------------------------------------
module move_to_front_coder
  import mtf_pkg::*;
#(
  parameter int LIST_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [SYM_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  result_value,
  output logic [STAT_W-1:0] status
);

  state_t            state;
  state_t            state_next;
  logic              direction;
  logic [LEN_W-1:0]  list_len;
  logic              full;
  logic              accept;
  logic              out_load;
  logic              scan_end;
  wave_t             launch;
  wave_t             tail;
  cell_ctl_t         cell_ctl;
  logic [SYM_W-1:0]  res_value;
  logic [STAT_W-1:0] res_status;

  wave_t             wave_bus [LIST_DEPTH+1];
  logic [SYM_W-1:0]  sym_bus  [LIST_DEPTH];
  logic [SYM_W-1:0]  prev_bus [LIST_DEPTH];

  assign cfg_ready   = 1'b1;
  assign accept      = in_valid && !in_stall;
  assign full        = list_len >= LEN_W'(LIST_DEPTH);
  assign wave_bus[0] = launch;
  assign tail        = wave_bus[LIST_DEPTH];
  assign prev_bus[0] = tail.data;

  genvar g;
  generate
    for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
      if (g > 0) begin : g_link
        assign prev_bus[g] = sym_bus[g-1];
      end
      mtf_cell #(
        .CELL_IDX (g)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctl      (cell_ctl),
        .prev_sym (prev_bus[g]),
        .wave_in  (wave_bus[g]),
        .wave_out (wave_bus[g+1]),
        .sym      (sym_bus[g])
      );
    end
  endgenerate

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (action == ACT_CODE) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (tail.live) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall           = state != ST_IDLE;
    out_load           = (state == ST_DONE) && (!out_valid || !out_stall);
    scan_end           = (state == ST_SCAN) && tail.live;
    cell_ctl.load_en   = accept && (action == ACT_APPEND) && !full;
    cell_ctl.load_sym  = value;
    cell_ctl.shift_en  = scan_end && tail.found;
    cell_ctl.shift_pos = tail.pos;
    cell_ctl.list_len  = list_len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      direction <= 1'b0;
      list_len  <= '0;
      launch.live <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        direction <= cfg_data;
      end
      launch.live   <= accept && (action == ACT_CODE);
      launch.decode <= direction;
      launch.found  <= 1'b0;
      launch.key    <= value;
      launch.pos    <= '0;
      launch.data   <= '0;
      if (accept) begin
        case (action)
          ACT_CLEAR:  list_len <= '0;
          ACT_APPEND: begin
            if (!full) begin
              list_len <= list_len + LEN_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_value  <= '0;
      res_status <= (action == ACT_APPEND && full) ? STATUS_FULL : STATUS_OK;
    end else if (scan_end) begin
      if (tail.found) begin
        res_value  <= tail.decode ? tail.data : tail.pos;
        res_status <= STATUS_OK;
      end else begin
        res_value  <= '0;
        res_status <= STATUS_MISS;
      end
    end
    if (out_load) begin
      result_value <= res_value;
      status       <= res_status;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    list_len <= LEN_W'(LIST_DEPTH))
    else $error("list length above depth");

  a_wave_in_scan: assert property (@(posedge clk) disable iff (rst)
    tail.live |-> state == ST_SCAN)
    else $error("wave reached tail outside scan");

  a_launch_scan: assert property (@(posedge clk) disable iff (rst)
    launch.live |-> state == ST_SCAN)
    else $error("wave launched without scan");

  a_shift_len: assert property (@(posedge clk) disable iff (rst)
    cell_ctl.shift_en |=> $stable(list_len))
    else $error("list length changed on move to front");

endmodule

@@ design/mtf_cell.sv @@
// ----------------------------------------------------------------------------
// mtf_cell
// One list slot. Holds a symbol, checks the passing search wave against it (or its index
// when decoding), hands the wave on, takes a new symbol on an append and its neighbor's on a move to front.
// ----------------------------------------------------------------------------
module mtf_cell
  import mtf_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [SYM_W-1:0] prev_sym,
  input  wave_t            wave_in,
  output wave_t            wave_out,
  output logic [SYM_W-1:0] sym
);

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(CELL_IDX);

  logic  in_range;
  logic  match;
  logic  hit;
  wave_t wave_next;

  always_comb begin
    in_range = MY_IDX < ctl.list_len;
    match    = wave_in.decode ? ({1'b0, wave_in.key} == MY_IDX) : (sym == wave_in.key);
    hit      = wave_in.live && !wave_in.found && in_range && match;
    wave_next = wave_in;
    if (hit) begin
      wave_next.found = 1'b1;
      wave_next.pos   = MY_IDX[SYM_W-1:0];
      wave_next.data  = sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.live <= 1'b0;
    end else begin
      wave_out <= wave_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_en && (ctl.list_len == MY_IDX)) begin
      sym <= ctl.load_sym;
    end else if (ctl.shift_en && (MY_IDX <= {1'b0, ctl.shift_pos})) begin
      sym <= prev_sym;
    end
  end

endmodule

@@ dv/move_to_front_coder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// move_to_front_coder_tb
// Self-checking bench for the move-to-front coder. A short directed sequence
// covers empty lists, duplicates, unused actions and range edges in both
// directions. It is followed by random phases. Each phase sets the direction
// register, loads an ascending alphabet (twice the full 256 symbols, then
// appends into the full list) and codes random symbols or indexes. Both sides
// see random idle bursts. A tracker class predicts every result and checks
// it in order.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [mtf_pkg::SYM_W-1:0]  result_value;
  logic [mtf_pkg::STAT_W-1:0] status;
} mtf_result_t;

class mtf_tracker;
  int depth;
  logic [mtf_pkg::SYM_W-1:0] sym_order[];
  int sym_count;
  bit decode_dir;
  mtf_result_t pending[$];
  int mismatches, encodes, decodes, misses, fulls, dir_writes;

  function new(int d);
    depth = d;
    sym_order = new[d];
    sym_count = 0;
    decode_dir = 1'b0;
  endfunction

  function void set_direction(logic dir);
    decode_dir = dir;
    dir_writes++;
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  // predict the result of one accepted item and update the list
  function void log_item(logic [mtf_pkg::ACT_W-1:0] act, logic [mtf_pkg::SYM_W-1:0] val);
    mtf_result_t r;
    int pos;
    logic [mtf_pkg::SYM_W-1:0] sym;
    r.result_value = '0;
    r.status = mtf_pkg::STATUS_OK;
    case (act)
      mtf_pkg::ACT_CLEAR: begin
        sym_count = 0;
      end
      mtf_pkg::ACT_APPEND: begin
        if (sym_count >= depth) begin
          r.status = mtf_pkg::STATUS_FULL;
          fulls++;
        end else begin
          sym_order[sym_count] = val;
          sym_count++;
        end
      end
      mtf_pkg::ACT_CODE: begin
        pos = -1;
        if (decode_dir) begin
          decodes++;
          if (int'(val) < sym_count) pos = int'(val);
        end else begin
          encodes++;
          for (int i = 0; i < sym_count; i++) begin
            if (pos < 0 && sym_order[i] == val) pos = i;
          end
        end
        if (pos < 0) begin
          r.status = mtf_pkg::STATUS_MISS;
          misses++;
        end else begin
          sym = sym_order[pos];
          r.result_value = decode_dir ? sym : 8'(pos);
          for (int j = pos; j > 0; j--) sym_order[j] = sym_order[j-1];
          sym_order[0] = sym;
        end
      end
      default: ;
    endcase
    pending.insert(pending.size(), r);
  endfunction

  function void check_result(logic [mtf_pkg::SYM_W-1:0] rv, logic [mtf_pkg::STAT_W-1:0] st);
    mtf_result_t want;
    if (pending.size() == 0) begin
      $error("unexpected result transfer: result_value %0d status %0d", rv, st);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (rv !== want.result_value) begin
      $error("result_value mismatch: expected %0d, actual %0d", want.result_value, rv);
      mismatches++;
    end
    if (st !== want.status) begin
      $error("status mismatch: expected %0d, actual %0d", want.status, st);
      mismatches++;
    end
  endfunction
endclass

module move_to_front_coder_tb;
  import mtf_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam int ITEM_TARGET = 1050;
  localparam int QUIET_AFTER = 900;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_data = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ACT_W-1:0]  action = '0;
  logic [SYM_W-1:0]  value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SYM_W-1:0]  result_value;
  logic [STAT_W-1:0] status;

  mtf_tracker tracker = new(LIST_DEPTH);
  int items_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  move_to_front_coder #(
    .LIST_DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_value(result_value),
    .status(status)
  );

  always #5 clk = ~clk;

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_direction(cfg_data);
      if (in_valid && !in_stall) tracker.log_item(action, value);
      if (out_valid && !out_stall) tracker.check_result(result_value, status);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // output backpressure bursts
  initial begin
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] val);
    in_valid <= 1'b1;
    action <= act;
    value <= val;
    do @(posedge clk); while (in_stall);
    if (act != ACT_UNUSED) items_sent++;
    @(negedge clk);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_direction(input logic dir);
    cfg_valid <= 1'b1;
    cfg_data <= dir;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic dir, input bit full_alpha);
    logic [SYM_W-1:0] alpha[$];
    logic [SYM_W-1:0] sym;
    int n, m, lim;
    n = full_alpha ? LIST_DEPTH : ($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 16));
    // now and then keep the old list to append on top of it
    if (full_alpha || $urandom_range(0, 9) != 0) send_item(ACT_CLEAR, 8'($urandom()));
    if (n > 0) begin
      sym = full_alpha ? 8'd0 : 8'($urandom_range(0, 256 - n));
      for (int i = 0; i < n; i++) begin
        send_item(ACT_APPEND, sym);
        alpha.insert(alpha.size(), sym);
        if (i < n - 1) begin
          lim = (255 - int'(sym)) - (n - 2 - i);
          if (lim > 24) lim = 24;
          sym = sym + 8'($urandom_range(1, lim));
        end
      end
    end
    if (full_alpha) begin
      repeat ($urandom_range(1, 3)) send_item(ACT_APPEND, 8'($urandom()));
    end
    m = full_alpha ? $urandom_range(8, 16) : $urandom_range(4, 24);
    for (int k = 0; k < m; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_item($urandom_range(0, 1) ? ACT_APPEND : ACT_UNUSED, 8'($urandom()));
      end else if (alpha.size() == 0 || $urandom_range(0, 7) == 0) begin
        send_item(ACT_CODE, 8'($urandom()));
      end else if (dir) begin
        send_item(ACT_CODE, 8'($urandom_range(0, alpha.size() - 1)));
      end else begin
        send_item(ACT_CODE, alpha[$urandom_range(0, alpha.size() - 1)]);
      end
    end
  endtask

  initial begin
    int phase;
    logic dir;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // encode direction after reset
    send_item(ACT_CODE, 8'h00);
    send_item(ACT_UNUSED, 8'hff);
    send_item(ACT_APPEND, 8'h00);
    send_item(ACT_APPEND, 8'h01);
    send_item(ACT_APPEND, 8'h80);
    send_item(ACT_APPEND, 8'hff);
    send_item(ACT_APPEND, 8'h00);
    send_item(ACT_CODE, 8'hff);
    send_item(ACT_CODE, 8'h00);
    send_item(ACT_CODE, 8'h00);
    send_item(ACT_CODE, 8'h55);
    send_item(ACT_CLEAR, 8'hff);
    send_item(ACT_CODE, 8'h00);
    drain();
    write_direction(1'b1);

    // decode direction
    send_item(ACT_CODE, 8'h00);
    send_item(ACT_APPEND, 8'h10);
    send_item(ACT_APPEND, 8'h20);
    send_item(ACT_APPEND, 8'h30);
    send_item(ACT_APPEND, 8'hff);
    send_item(ACT_CODE, 8'd3);
    send_item(ACT_CODE, 8'd0);
    send_item(ACT_CODE, 8'd4);
    send_item(ACT_CODE, 8'd255);
    send_item(ACT_CODE, 8'd2);
    send_item(ACT_UNUSED, 8'h00);
    send_item(ACT_CLEAR, 8'h00);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      dir = (phase == 2) ? 1'b0 : (phase == 9) ? 1'b1 : 1'($urandom_range(0, 1));
      drain();
      write_direction(dir);
      if (items_sent > QUIET_AFTER) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 30;
        endcase
      end
      run_phase(dir, phase == 2 || phase == 9);
      phase++;
    end

    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (LIST_DEPTH + 8) @(negedge clk);

    $display("covered %0d item transfers over %0d phases: %0d encodes, %0d decodes",
             items_sent, phase, tracker.encodes, tracker.decodes);
    $display("%0d misses, %0d appends into a full list, %0d direction writes",
             tracker.misses, tracker.fulls, tracker.dir_writes);
    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mtf_pkg.sv
design/mtf_cell.sv
design/move_to_front_coder.sv
dv/move_to_front_coder_tb.sv
